// File: hw/rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// Spiral colour match search: shared package
// Field widths, register indexes, the queue word and queue status types.
// ----------------------------------------------------------------------------
package scm_pkg;

   localparam int COLOUR_W    = 8;
   localparam int COORD_W     = 12;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 12;

   // Spiral arithmetic: offsets are 13-bit signed, held at 15 bits so that
   // doubling and negation never overflow.
   localparam int OFS_W  = 15;
   localparam int RUN_W  = 14;
   localparam int ADD_W  = 14;
   localparam int STEP_W = 2 * RUN_W;

   localparam int DEF_WALK_SIDE = 150;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_RED_LOW    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_HIGH   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_LOW  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_HIGH = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_LOW   = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_HIGH  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTRE_COL = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTRE_ROW = 4'd7;

   // One classified pixel on its way from front to back.
   typedef struct packed {
      logic               hit;
      logic               last;
      logic [RUN_W-1:0]   run_len;
      logic [ADD_W-1:0]   run_add;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } scm_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } scm_qstat_type;

endpackage

// File: hw/rtl/scm_front.sv
// ----------------------------------------------------------------------------
// Spiral colour match search: front end
// Holds the configuration registers, takes pixels in and classifies them:
// colour box test, spiral run selection, run length and offset along it.
// ----------------------------------------------------------------------------
module scm_front
   import scm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COLOUR_W-1:0]    req_red,
   input  logic [COLOUR_W-1:0]    req_green,
   input  logic [COLOUR_W-1:0]    req_blue,
   input  logic [COORD_W-1:0]     req_pixel_col,
   input  logic [COORD_W-1:0]     req_pixel_row,
   input  logic                   req_frame_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  scm_qstat_type          qstat,
   output logic                   push,
   output scm_item_type           push_item
);

   localparam logic signed [OFS_W-1:0] ZERO = '0;
   localparam logic signed [OFS_W-1:0] ONE  = OFS_W'(1);
   localparam logic signed [OFS_W-1:0] TWO  = OFS_W'(2);

   logic [COLOUR_W-1:0] red_low_ff, red_high_ff, green_low_ff, green_high_ff;
   logic [COLOUR_W-1:0] blue_low_ff, blue_high_ff;
   logic [COORD_W-1:0]  centre_col_ff, centre_row_ff;

   logic                valid_ff, valid_in;
   logic [COLOUR_W-1:0] red_ff, green_ff, blue_ff;
   logic [COORD_W-1:0]  col_ff, row_ff;
   logic                last_ff;

   logic                    accept;
   logic                    colour_ok;
   logic                    on_run;
   logic signed [OFS_W-1:0] x, y, n_s, add_s;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_low_ff     <= '0;
         red_high_ff    <= '0;
         green_low_ff   <= '0;
         green_high_ff  <= '0;
         blue_low_ff    <= '0;
         blue_high_ff   <= '0;
         centre_col_ff  <= '0;
         centre_row_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RED_LOW:    red_low_ff    <= csr_wdata[COLOUR_W-1:0];
            REG_RED_HIGH:   red_high_ff   <= csr_wdata[COLOUR_W-1:0];
            REG_GREEN_LOW:  green_low_ff  <= csr_wdata[COLOUR_W-1:0];
            REG_GREEN_HIGH: green_high_ff <= csr_wdata[COLOUR_W-1:0];
            REG_BLUE_LOW:   blue_low_ff   <= csr_wdata[COLOUR_W-1:0];
            REG_BLUE_HIGH:  blue_high_ff  <= csr_wdata[COLOUR_W-1:0];
            REG_CENTRE_COL: centre_col_ff <= csr_wdata[COORD_W-1:0];
            REG_CENTRE_ROW: centre_row_ff <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // The input register empties into the queue whenever the queue has room.
   assign push      = valid_ff && !qstat.full;
   assign req_stall = valid_ff && qstat.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         col_ff   <= req_pixel_col;
         row_ff   <= req_pixel_row;
         last_ff  <= req_frame_end;
      end
   end

   assign colour_ok = (red_ff   >= red_low_ff)   && (red_ff   <= red_high_ff)   &&
                      (green_ff >= green_low_ff) && (green_ff <= green_high_ff) &&
                      (blue_ff  >= blue_low_ff)  && (blue_ff  <= blue_high_ff);

   // Offsets from the centre, y growing downward. The four runs are tried
   // in walk order, so a corner belongs to the first run that claims it.
   always_comb begin
      x      = $signed({3'b000, col_ff}) - $signed({3'b000, centre_col_ff});
      y      = $signed({3'b000, row_ff}) - $signed({3'b000, centre_row_ff});
      on_run = 1'b1;
      n_s    = ZERO;
      add_s  = ZERO;
      if (x <= ZERO && y >= x - ONE && y <= -x - ONE) begin
         n_s   = ONE - (x <<< 1);
         add_s = -x - y;
      end else if (y <= -ONE && x >= y + TWO && x <= -y) begin
         n_s   = -(y <<< 1) - ONE;
         add_s = n_s + x - y - ONE;
      end else if (x >= ONE && y >= ONE - x && y <= x) begin
         n_s   = x <<< 1;
         add_s = x + y;
      end else if (y >= ONE && x >= -y && x <= y - ONE) begin
         n_s   = y <<< 1;
         add_s = n_s + y - x;
      end else begin
         on_run = 1'b0;
      end
   end

   always_comb begin
      push_item.hit     = colour_ok && on_run;
      push_item.last    = last_ff;
      push_item.run_len = n_s[RUN_W-1:0];
      push_item.run_add = add_s[ADD_W-1:0];
      push_item.col     = col_ff;
      push_item.row     = row_ff;
   end

endmodule

// File: hw/rtl/scm_queue.sv
// ----------------------------------------------------------------------------
// Spiral colour match search: decoupling queue
// A short first-in first-out store of classified pixels between front and back.
// ----------------------------------------------------------------------------
module scm_queue
   import scm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  scm_item_type  push_item,
   input  logic          pop,
   output scm_item_type  pop_item,
   output scm_qstat_type qstat
);

   scm_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
   end

   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/scm_back.sv
// ----------------------------------------------------------------------------
// Spiral colour match search: back end
// Turns run length and offset into a walk rank, keeps the lowest-rank match
// and delivers the frame result through an output register.
// ----------------------------------------------------------------------------
module scm_back
   import scm_pkg::*;
#(
   parameter int WALK_SIDE = DEF_WALK_SIDE
)
(
   input  logic                clock,
   input  logic                reset,
   input  scm_qstat_type       qstat,
   input  scm_item_type        pop_item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [COORD_W-1:0]  rsp_match_col,
   output logic [COORD_W-1:0]  rsp_match_row
);

   localparam int WALK_LEN = WALK_SIDE * WALK_SIDE;
   localparam int RANK_W   = $clog2(WALK_LEN);

   logic                adv;

   logic                s1_valid_ff;
   logic                s1_hit_ff, s1_last_ff;
   logic [STEP_W-1:0]   s1_prod_ff;
   logic [ADD_W-1:0]    s1_add_ff;
   logic [COORD_W-1:0]  s1_col_ff, s1_row_ff;

   logic [RANK_W-1:0]   best_rank_ff;
   logic [COORD_W-1:0]  best_col_ff, best_row_ff;
   logic                have_ff;

   logic                rsp_valid_ff;
   logic                found_ff;
   logic [COORD_W-1:0]  match_col_ff, match_row_ff;

   logic [STEP_W-1:0]   step;
   logic [RANK_W-1:0]   rank;
   logic                in_walk, better;
   logic                have_in;
   logic [COORD_W-1:0]  col_in, row_in;

   // The whole back end moves only when the output register can take a word.
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= !qstat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_hit_ff  <= pop_item.hit;
         s1_last_ff <= pop_item.last;
         s1_prod_ff <= STEP_W'(pop_item.run_len) *
                       (STEP_W'(pop_item.run_len) - STEP_W'(1));
         s1_add_ff  <= pop_item.run_add;
         s1_col_ff  <= pop_item.col;
         s1_row_ff  <= pop_item.row;
      end
   end

   always_comb begin
      step    = s1_prod_ff + STEP_W'(s1_add_ff);
      rank    = RANK_W'(step - STEP_W'(1));
      in_walk = s1_hit_ff && (step != '0) && (step <= STEP_W'(WALK_LEN));
      better  = in_walk && (!have_ff || rank < best_rank_ff);
      have_in = have_ff || better;
      col_in  = better ? s1_col_ff : best_col_ff;
      row_in  = better ? s1_row_ff : best_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_rank_ff <= '1;
         best_col_ff  <= '0;
         best_row_ff  <= '0;
         have_ff      <= 1'b0;
      end else if (adv && s1_valid_ff) begin
         if (s1_last_ff) begin
            best_rank_ff <= '1;
            best_col_ff  <= '0;
            best_row_ff  <= '0;
            have_ff      <= 1'b0;
         end else if (better) begin
            best_rank_ff <= rank;
            best_col_ff  <= s1_col_ff;
            best_row_ff  <= s1_row_ff;
            have_ff      <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff && s1_last_ff) begin
         found_ff     <= have_in;
         match_col_ff <= have_in ? col_in : '0;
         match_row_ff <= have_in ? row_in : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_match_col = match_col_ff;
   assign rsp_match_row = match_row_ff;

endmodule

// File: hw/rtl/spiral_color_match_search_core.sv
// ----------------------------------------------------------------------------
// Spiral colour match search core
// Finds the colour-box match that comes first in a square spiral walk.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel, one word per pixel with its colour,
// column, row and an end-of-frame flag; a word is taken at a clock edge
// where req_valid is high and req_stall is low. The csr_ channel writes the
// colour bounds and the spiral centre by register index; it is always ready
// and should be written only while no frame is in flight.
// One pixel is taken every cycle while req_stall is low. The front end
// registers and classifies a pixel, a four-word queue decouples it from the
// back end, which spends one stage on the run-length multiply and one on
// the rank compare and update. The frame result reaches the rsp_ channel
// through the input register, the queue, the multiply stage and the output
// register, where it is held until rsp_stall is low. While that register is
// stalled the back end waits, the queue fills and req_stall rises once it
// and the input register are full. Reset clears the configuration registers,
// the queue and the kept match; no result is pending afterwards.
// ----------------------------------------------------------------------------
module spiral_color_match_search_core
   import scm_pkg::*;
#(
   parameter int WALK_SIDE = DEF_WALK_SIDE
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COLOUR_W-1:0]    req_red,
   input  logic [COLOUR_W-1:0]    req_green,
   input  logic [COLOUR_W-1:0]    req_blue,
   input  logic [COORD_W-1:0]     req_pixel_col,
   input  logic [COORD_W-1:0]     req_pixel_row,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_found,
   output logic [COORD_W-1:0]     rsp_match_col,
   output logic [COORD_W-1:0]     rsp_match_row,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          push, pop;
   scm_item_type  push_item, pop_item;
   scm_qstat_type qstat;

   scm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .req_frame_end (req_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .qstat         (qstat),
      .push          (push),
      .push_item     (push_item)
   );

   scm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   scm_back #(
      .WALK_SIDE (WALK_SIDE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .pop_item      (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_match_col (rsp_match_col),
      .rsp_match_row (rsp_match_row)
   );

endmodule
